// ===== rtl/trigram_text_hypervector_encoder_defines.svh =====
// assertion macros for the trigram encoder checker
`ifndef TRIGRAM_TEXT_HYPERVECTOR_ENCODER_DEFINES_SVH
`define TRIGRAM_TEXT_HYPERVECTOR_ENCODER_DEFINES_SVH
`define ASSERT_IMPL(lbl, clk_s, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`define ASSERT_NEXT(lbl, clk_s, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`endif

// ===== rtl/tthe_pkg.sv =====
`timescale 1ns / 1ps
package tthe_pkg;
	localparam int unsigned VectorBitsDefault = 1024;
	localparam int unsigned MaxWindowsDefault = 256;
	localparam logic [63:0] MixGamma = 64'h9E3779B97F4A7C15;
	localparam logic [63:0] MixMulA = 64'hBF58476D1CE4E5B9;
	localparam logic [63:0] MixMulB = 64'h94D049BB133111EB;
	localparam logic [63:0] HashStart = 64'd5381;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CLEAR,
		ST_EXPAND,
		ST_EMIT
	} tthe_state_t;

	typedef struct packed {
		logic load_seed;
		logic load_short;
		logic step_word;
		logic accum_en;
		logic emit_load;
		logic clear_word;
		logic take_byte;
		logic use_code;
	} tthe_cmd_t;

	typedef struct packed {
		logic window_ok;
		logic word_last;
		logic mix_ready;
		logic no_windows;
	} tthe_status_t;

	function automatic logic [63:0] hash_add(input logic [63:0] h, input logic [7:0] b);
		hash_add = (h << 5) + h + {56'd0, b};
	endfunction
endpackage

// ===== rtl/tthe_datapath.sv =====
`timescale 1ns / 1ps
module tthe_datapath #(
	parameter int unsigned VECTOR_BITS = 1024,
	parameter int unsigned MAX_WINDOWS = 256
) (
	input  logic                clk,
	input  logic                arst_n,
	input  tthe_pkg::tthe_cmd_t cmd,
	output tthe_pkg::tthe_status_t status,
	input  logic [7:0]          text_byte,
	output logic [3:0]          word_index,
	output logic [63:0]         vector_word,
	output logic                last_word
);
	import tthe_pkg::*;
	localparam int unsigned NumWords = VECTOR_BITS / 64;
	localparam int unsigned WBits = (NumWords > 1) ? $clog2(NumWords) : 1;
	localparam int unsigned CBits = $clog2(MAX_WINDOWS + 1) + 1;

	logic [7:0]       older_q, newer_q;
	logic [1:0]       seen_q;
	logic [CBits-1:0] wcount_q;
	logic [63:0]      acc_q;
	logic [63:0]      pa_lo_s1, z1_s2, pb_lo_s3, z2_s4, code_s5;
	logic [31:0]      pa_hi_s1, pb_hi_s3;
	logic [4:0]       vld_q;
	logic [WBits-1:0] widx_q, acc_w_s5;
	logic [WBits-1:0] w_s1, w_s2, w_s3, w_s4;
	logic [63:0][CBits-1:0] cnt_q [NumWords];
	logic [63:0][CBits-1:0] cnt_inc;
	logic [63:0]      z0, maj, x1, x2;
	logic [63:0]      seed;

	assign status.window_ok = (seen_q >= 2'd2) && (wcount_q < CBits'(MAX_WINDOWS));
	assign status.word_last = (widx_q == WBits'(NumWords - 1));
	assign status.mix_ready = vld_q[4];
	assign status.no_windows = (wcount_q == '0);

	always_comb begin
		seed = hash_add(hash_add(hash_add(HashStart, older_q), newer_q), text_byte);
		if (cmd.load_short) begin
			seed = (seen_q != 2'd0) ? hash_add(hash_add(HashStart, newer_q), text_byte)
				: hash_add(HashStart, text_byte);
		end
		z0 = acc_q + MixGamma;
		x1 = z0 ^ (z0 >> 30);
		x2 = z1_s2 ^ (z1_s2 >> 27);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			older_q <= '0;
			newer_q <= '0;
			seen_q <= '0;
			wcount_q <= '0;
			vld_q <= '0;
			widx_q <= '0;
		end else begin
			vld_q <= {vld_q[3:0], cmd.step_word};
			if (cmd.step_word || cmd.emit_load || cmd.clear_word) begin
				widx_q <= status.word_last ? '0 : widx_q + 1'b1;
			end
			if (cmd.take_byte) begin
				older_q <= newer_q;
				newer_q <= text_byte;
				if (seen_q != 2'd3) seen_q <= seen_q + 2'd1;
				if (status.window_ok) wcount_q <= wcount_q + 1'b1;
			end
			if (cmd.clear_word && status.word_last) begin
				older_q <= '0;
				newer_q <= '0;
				seen_q <= '0;
				wcount_q <= '0;
			end
		end
	end

	// 64-bit products built from 32-bit halves, two stages per multiply
	always_ff @(posedge clk) begin
		if (cmd.load_seed || cmd.load_short) begin
			acc_q <= seed;
		end else if (cmd.step_word) begin
			acc_q <= z0;
		end
		pa_lo_s1 <= {32'd0, x1[31:0]} * {32'd0, MixMulA[31:0]};
		pa_hi_s1 <= x1[31:0] * MixMulA[63:32] + x1[63:32] * MixMulA[31:0];
		w_s1 <= widx_q;
		z1_s2 <= pa_lo_s1 + {pa_hi_s1, 32'd0};
		w_s2 <= w_s1;
		pb_lo_s3 <= {32'd0, x2[31:0]} * {32'd0, MixMulB[31:0]};
		pb_hi_s3 <= x2[31:0] * MixMulB[63:32] + x2[63:32] * MixMulB[31:0];
		w_s3 <= w_s2;
		z2_s4 <= pb_lo_s3 + {pb_hi_s3, 32'd0};
		w_s4 <= w_s3;
		code_s5 <= z2_s4 ^ (z2_s4 >> 31);
		acc_w_s5 <= w_s4;
	end

	always_comb begin
		for (int b = 0; b < 64; b++) begin
			maj[b] = ({cnt_q[widx_q][b], 1'b0} > {1'b0, wcount_q});
			cnt_inc[b] = cnt_q[acc_w_s5][b] + {{(CBits-1){1'b0}}, code_s5[b]};
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.clear_word) begin
			cnt_q[widx_q] <= '0;
		end else if (cmd.accum_en && vld_q[4]) begin
			cnt_q[acc_w_s5] <= cnt_inc;
		end
		if (cmd.emit_load) begin
			vector_word <= maj;
			word_index <= 4'(widx_q);
			last_word <= status.word_last;
		end else if (cmd.use_code && vld_q[4]) begin
			vector_word <= code_s5;
			word_index <= 4'(acc_w_s5);
			last_word <= (acc_w_s5 == WBits'(NumWords - 1));
		end
	end
endmodule

// ===== rtl/tthe_control.sv =====
`timescale 1ns / 1ps
module tthe_control (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic                  end_of_text,
	input  tthe_pkg::tthe_status_t status,
	output tthe_pkg::tthe_cmd_t   cmd,
	output logic                  out_valid,
	input  logic                  out_ready
);
	import tthe_pkg::*;
	localparam logic [2:0] DrainLong = 3'd4;
	localparam logic [2:0] DrainShort = 3'd5;
	tthe_state_t state_q, state_d;
	logic eot_q, eot_d, short_q, short_d, ov_q, ov_d, issue_q, issue_d;
	logic [2:0] drain_q, drain_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			eot_q <= 1'b0;
			short_q <= 1'b0;
			ov_q <= 1'b0;
			issue_q <= 1'b0;
			drain_q <= '0;
		end else begin
			state_q <= state_d;
			eot_q <= eot_d;
			short_q <= short_d;
			ov_q <= ov_d;
			issue_q <= issue_d;
			drain_q <= drain_d;
		end
	end

	assign out_valid = ov_q;

	always_comb begin
		state_d = state_q;
		eot_d = eot_q;
		short_d = short_q;
		issue_d = issue_q;
		drain_d = drain_q;
		ov_d = ov_q && !out_ready;
		cmd = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.take_byte = 1'b1;
					eot_d = end_of_text;
					if (status.window_ok) begin
						cmd.load_seed = 1'b1;
						short_d = 1'b0;
						issue_d = 1'b1;
						drain_d = '0;
						state_d = ST_EXPAND;
					end else if (end_of_text && status.no_windows) begin
						cmd.load_short = 1'b1;
						short_d = 1'b1;
						issue_d = 1'b1;
						drain_d = '0;
						state_d = ST_EXPAND;
					end else if (end_of_text) begin
						short_d = 1'b0;
						state_d = ST_EMIT;
					end
				end
			end
			ST_EXPAND: begin
				cmd.accum_en = !short_q;
				cmd.use_code = short_q;
				if (short_q && status.mix_ready) ov_d = 1'b1;
				if (issue_q && (!short_q || (drain_q == 3'd0 && (!ov_q || out_ready)))) begin
					cmd.step_word = 1'b1;
					if (short_q) drain_d = DrainShort;
					if (status.word_last) begin
						issue_d = 1'b0;
						drain_d = short_q ? DrainShort : DrainLong;
					end
				end else if (drain_q != 3'd0) begin
					drain_d = drain_q - 3'd1;
				end else if (!issue_q) begin
					if (short_q) begin
						state_d = ST_CLEAR;
					end else begin
						state_d = eot_q ? ST_EMIT : ST_IDLE;
					end
				end
			end
			ST_EMIT: begin
				if (!ov_q || out_ready) begin
					if (status.window_ok || short_q) begin
						state_d = ST_EMIT;
					end
					cmd.emit_load = 1'b1;
					ov_d = 1'b1;
					if (status.word_last) state_d = ST_CLEAR;
				end
			end
			ST_CLEAR: begin
				if (!ov_q || out_ready) begin
					cmd.clear_word = 1'b1;
					if (status.word_last) state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end
endmodule

// ===== rtl/trigram_text_hypervector_encoder.sv =====
`timescale 1ns / 1ps
// channel | signals                                 | role
// in      | in_valid in_ready text_byte end_of_text | one text byte per item
// out     | out_valid out_ready word_index ...      | one 64-bit word per item
// a byte completing a counted window expands into NUM_WORDS mixer words (one mixer word a cycle)
// other bytes are taken in the idle state; end of text emits NUM_WORDS items then clears counters,
// one word of counters per cycle while the output is not stalled
// a text under three bytes emits its code words one at a time, each once the last has left the mixer
// after reset the counters are cleared one word at a time before the first item
// output stalls hold the emit sequence; reset clears all control state
module trigram_text_hypervector_encoder
	import tthe_pkg::*;
#(
	parameter int unsigned VECTOR_BITS = VectorBitsDefault,
	parameter int unsigned MAX_WINDOWS = MaxWindowsDefault
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  text_byte,
	input  logic        end_of_text,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [3:0]  word_index,
	output logic [63:0] vector_word,
	output logic        last_word
);
	tthe_cmd_t    cmd;
	tthe_status_t status;

	tthe_control u_ctrl (
		.clk, .arst_n, .in_valid, .in_ready, .end_of_text,
		.status, .cmd, .out_valid, .out_ready
	);

	tthe_datapath #(.VECTOR_BITS(VECTOR_BITS), .MAX_WINDOWS(MAX_WINDOWS)) u_dp (
		.clk, .arst_n, .cmd, .status, .text_byte,
		.word_index, .vector_word, .last_word
	);
endmodule

// ===== rtl/tthe_checker.sv =====
`timescale 1ns / 1ps
`include "trigram_text_hypervector_encoder_defines.svh"
module tthe_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [3:0]  word_index,
	input logic        last_word
);
	`ASSERT_NEXT(out_hold, clk, arst_n, out_valid && !out_ready, out_valid)
	`ASSERT_NEXT(in_hold, clk, arst_n, in_valid && !in_ready, in_valid)
	`ASSERT_IMPL(last_on_top, clk, arst_n, out_valid && last_word, word_index == 4'd15)
	`ASSERT_IMPL(no_in_while_out, clk, arst_n, out_valid, !in_ready)
endmodule

bind trigram_text_hypervector_encoder tthe_checker u_chk (
	.clk, .arst_n, .in_valid, .in_ready, .out_valid, .out_ready, .word_index, .last_word
);
